### design/ftr_pkg.sv
// Shared types and constants for the fragment reassembly tracker.
// No dependencies.
package ftr_pkg;

  localparam int SEQ_W = 16;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_SIZE     = 4'd1;
  localparam logic [3:0] ST_COUNT    = 4'd2;
  localparam logic [3:0] ST_INDEX    = 4'd3;
  localparam logic [3:0] ST_SHORT    = 4'd4;
  localparam logic [3:0] ST_WINDOW   = 4'd5;
  localparam logic [3:0] ST_BUSY     = 4'd6;
  localparam logic [3:0] ST_MISMATCH = 4'd7;
  localparam logic [3:0] ST_DUP      = 4'd8;

  localparam logic [2:0] REG_MAX_DIST = 3'd0;
  localparam logic [15:0] MAX_DIST_RESET = 16'd1024;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MOD,
    S_LOOK,
    S_CHECK,
    S_SWEEP
  } state_t;

  // a strictly newer than b in 16-bit wrapped order
  function automatic logic seq_newer(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] dab;
    logic [SEQ_W-1:0] dba;
    dab = a - b;
    dba = b - a;
    return ((a > b) && (dab <= 16'd32768)) || ((a < b) && (dba > 16'd32768));
  endfunction

endpackage

### design/fragment_reassembly_tracker.sv
// Fragment reassembly tracker: header checks, slot bookkeeping, eviction.
// Uses ftr_pkg, ftr_slot_mem, ftr_apb_regs.
//
// One fragment header beat in (in_valid/in_stall), one status beat out
// (out_valid/out_stall) per header. Headers are handled one at a time:
// the slot index is formed by a reciprocal multiply, then a remainder,
// the slot record is read from memory, and the check and write-back
// follow. A header that opens a slot for a newer sequence first sweeps
// every slot through the memory read port to evict stale packets.
// in_stall is high while a header is in flight. The finished result sits
// in an output register; a stalled receiver holds it there and the block
// keeps the next header waiting in the check step until that beat leaves.
// Reset (synchronous) clears the valid bits of all slots, the held count
// and the current sequence, and sets the window register to 1024; no
// memory clearing pass is needed. APB register 0 at address 0 is the
// window distance; writes are taken at any time, pready is always high.
module fragment_reassembly_tracker #(
  parameter int SLOT_COUNT = 256,
  parameter int MAX_FRAGMENT_BYTES = 1024,
  parameter int MAX_FRAGMENTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] packet_sequence,
  input  logic [7:0]  fragment_index,
  input  logic [7:0]  fragment_total,
  input  logic [10:0] fragment_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic        packet_complete,
  output logic [15:0] completed_sequence,
  output logic [18:0] packet_bytes,
  output logic [15:0] buffered_fragments
);

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int FW = $clog2(MAX_FRAGMENTS);
  localparam int MW = MAX_FRAGMENTS;
  localparam int DW = 16 + 8 + 8 + 11 + MW;
  localparam longint unsigned RECIP_L =
    ((64'd1 << 32) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT);
  localparam logic [31:0] RECIP = 32'(RECIP_L);

  ftr_pkg::state_t state, state_next;

  logic [15:0] max_dist;
  logic [15:0] cur_seq;
  logic [15:0] held;
  logic [SLOT_COUNT-1:0] slot_valid;

  logic [15:0] it_seq;
  logic [7:0]  it_idx;
  logic [7:0]  it_tot;
  logic [10:0] it_bytes;
  logic [15:0] quot;
  logic [SW-1:0] slot;

  logic [CW-1:0] cnt;
  logic          pend;
  logic [SW-1:0] pend_idx;

  logic          wr_en;
  logic [DW-1:0] wr_data;
  logic [SW-1:0] rd_addr;
  logic [DW-1:0] rd_data;

  logic [15:0]   rd_seq;
  logic [7:0]    rd_tot;
  logic [7:0]    rd_cnt;
  logic [10:0]   rd_last;
  logic [MW-1:0] rd_map;

  assign {rd_seq, rd_tot, rd_cnt, rd_last, rd_map} = rd_data;

  ftr_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .max_dist(max_dist)
  );
  assign pready = 1'b1;

  ftr_slot_mem #(.SLOT_COUNT(SLOT_COUNT), .DW(DW)) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(slot),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // slot index: seq / N via reciprocal, then remainder
  logic [47:0] prod;
  logic [26:0] qn;
  logic [26:0] rem;
  assign prod = 48'(it_seq) * 48'(RECIP);
  assign qn   = 27'(quot) * 27'(SLOT_COUNT);
  assign rem  = 27'(it_seq) - qn;

  // header checks
  logic [3:0]  base_st;
  logic [15:0] seq_dist;
  logic        ahead_far;
  always_comb begin
    seq_dist = it_seq - cur_seq;
    if (!seq_dist[15]) begin
      ahead_far = seq_dist > max_dist;
    end else if (seq_dist == 16'd32768 && it_seq < cur_seq) begin
      ahead_far = !max_dist[15];
    end else begin
      ahead_far = 1'b0;
    end
    if (it_bytes == 11'd0 || 32'(it_bytes) > MAX_FRAGMENT_BYTES) begin
      base_st = ftr_pkg::ST_SIZE;
    end else if (it_tot == 8'd0 || 32'(it_tot) > MAX_FRAGMENTS) begin
      base_st = ftr_pkg::ST_COUNT;
    end else if (it_idx >= it_tot) begin
      base_st = ftr_pkg::ST_INDEX;
    end else if (it_idx != it_tot - 8'd1 && 32'(it_bytes) != MAX_FRAGMENT_BYTES) begin
      base_st = ftr_pkg::ST_SHORT;
    end else if (ahead_far) begin
      base_st = ftr_pkg::ST_WINDOW;
    end else begin
      base_st = ftr_pkg::ST_OK;
    end
  end

  // slot lookup and update; an invalid slot reads as empty
  logic          v;
  logic [7:0]    cnt_s;
  logic [7:0]    tot_s;
  logic [MW-1:0] map_s;
  logic [3:0]    st;
  logic          need_evict;
  logic [MW-1:0] map_n;
  logic [7:0]    cnt_n;
  logic [10:0]   last_n;
  logic          complete;
  logic [19:0]   sum;
  logic [15:0]   held_inc;
  logic [15:0]   held_done;
  logic          out_ok;
  logic          commit;
  always_comb begin
    v        = slot_valid[slot];
    cnt_s    = v ? rd_cnt : 8'd0;
    tot_s    = v ? rd_tot : it_tot;
    map_s    = v ? rd_map : '0;
    st       = base_st;
    need_evict = 1'b0;
    if (st == ftr_pkg::ST_OK && v && rd_seq != it_seq) begin
      st = ftr_pkg::ST_BUSY;
    end
    if (st == ftr_pkg::ST_OK && !v && ftr_pkg::seq_newer(it_seq, cur_seq)) begin
      need_evict = 1'b1;
    end
    if (st == ftr_pkg::ST_OK && it_tot != tot_s) begin
      st = ftr_pkg::ST_MISMATCH;
    end
    if (st == ftr_pkg::ST_OK && map_s[it_idx[FW-1:0]]) begin
      st = ftr_pkg::ST_DUP;
    end
    map_n    = map_s | (MW'(1) << it_idx[FW-1:0]);
    cnt_n    = cnt_s + 8'd1;
    last_n   = (it_idx == it_tot - 8'd1) ? it_bytes : rd_last;
    complete = (st == ftr_pkg::ST_OK) && (cnt_n == tot_s);
    sum      = 20'(tot_s - 8'd1) * 20'(MAX_FRAGMENT_BYTES) + 20'(last_n);
    held_inc = held + 16'd1;
    held_done = (held_inc >= 16'(tot_s)) ? held_inc - 16'(tot_s) : 16'd0;
    out_ok   = !out_valid || !out_stall;
    commit   = (state == ftr_pkg::S_CHECK) && !need_evict && out_ok;
    wr_en    = commit && (st == ftr_pkg::ST_OK);
    wr_data  = {it_seq, tot_s, cnt_n, last_n, map_n};
  end

  // sweep: oldest sequence kept after advancing to it_seq
  logic [15:0] oldest;
  logic        evict_hit;
  assign oldest    = it_seq - 16'(SLOT_COUNT) + 16'd1;
  assign evict_hit = pend && slot_valid[pend_idx] && ftr_pkg::seq_newer(oldest, rd_seq);

  always_comb begin
    state_next = state;
    rd_addr    = slot;
    in_stall   = (state != ftr_pkg::S_IDLE);
    case (state)
      ftr_pkg::S_IDLE: begin
        if (in_valid) state_next = ftr_pkg::S_DIV;
      end
      ftr_pkg::S_DIV:  state_next = ftr_pkg::S_MOD;
      ftr_pkg::S_MOD:  state_next = ftr_pkg::S_LOOK;
      ftr_pkg::S_LOOK: state_next = ftr_pkg::S_CHECK;
      ftr_pkg::S_CHECK: begin
        if (need_evict) begin
          state_next = ftr_pkg::S_SWEEP;
        end else if (out_ok) begin
          state_next = ftr_pkg::S_IDLE;
        end
      end
      ftr_pkg::S_SWEEP: begin
        if (cnt != CW'(SLOT_COUNT)) begin
          rd_addr = cnt[SW-1:0];
        end
        if (cnt == CW'(SLOT_COUNT) && !pend) begin
          state_next = ftr_pkg::S_CHECK;
        end
      end
      default: state_next = ftr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ftr_pkg::S_IDLE && in_valid) begin
      it_seq   <= packet_sequence;
      it_idx   <= fragment_index;
      it_tot   <= fragment_total;
      it_bytes <= fragment_bytes;
    end
    if (state == ftr_pkg::S_DIV) begin
      quot <= prod[47:32];
    end
    if (state == ftr_pkg::S_MOD) begin
      slot <= rem[SW-1:0];
    end
    if (commit) begin
      status             <= st;
      packet_complete    <= complete;
      completed_sequence <= complete ? it_seq : 16'd0;
      packet_bytes       <= !complete ? 19'd0 : (sum[19] ? 19'h7FFFF : sum[18:0]);
      buffered_fragments <= (st != ftr_pkg::ST_OK) ? held :
                            (complete ? held_done : held_inc);
    end
    pend_idx <= cnt[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_seq    <= 16'd0;
      held       <= 16'd0;
      slot_valid <= '0;
      out_valid  <= 1'b0;
      cnt        <= '0;
      pend       <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ftr_pkg::S_CHECK) begin
        cnt  <= '0;
        pend <= 1'b0;
      end
      if (commit) begin
        if (st == ftr_pkg::ST_OK) begin
          slot_valid[slot] <= !complete;
          held <= complete ? held_done : held_inc;
        end
      end
      if (state == ftr_pkg::S_SWEEP) begin
        pend <= (cnt != CW'(SLOT_COUNT));
        if (cnt != CW'(SLOT_COUNT)) begin
          cnt <= cnt + CW'(1);
        end
        if (evict_hit) begin
          slot_valid[pend_idx] <= 1'b0;
          held <= (held >= 16'(rd_cnt)) ? held - 16'(rd_cnt) : 16'd0;
        end
        if (cnt == CW'(SLOT_COUNT) && !pend) begin
          cur_seq <= it_seq;
        end
      end
    end
  end

endmodule

### design/ftr_slot_mem.sv
// Slot record memory: one write port, one registered read port.
// Depends on nothing.
module ftr_slot_mem #(
  parameter int SLOT_COUNT = 256,
  parameter int DW = 32
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  input  logic [DW-1:0]                 wr_data,
  input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  output logic [DW-1:0]                 rd_data
);

  logic [DW-1:0] mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### design/ftr_apb_regs.sv
// APB register file: the sequence window register.
// Uses ftr_pkg.
module ftr_apb_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [15:0] max_dist
);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist <= ftr_pkg::MAX_DIST_RESET;
    end else if (psel && penable && pwrite && paddr == ftr_pkg::REG_MAX_DIST) begin
      max_dist <= pwdata[15:0];
    end
  end

  assign prdata = (paddr == ftr_pkg::REG_MAX_DIST) ? {16'd0, max_dist} : 32'd0;

endmodule

### sim/tb_fragment_reassembly_tracker.sv
// Testbench for fragment_reassembly_tracker: header checks, slot tracking,
// eviction and completion, checked beat by beat against an in-bench predictor.
// Depends on ftr_pkg and the tracker RTL.
`timescale 1ns / 100ps

module tb_fragment_reassembly_tracker;

  localparam int NSLOT = 256;
  localparam int MAXB = 1024;
  localparam int MAXF = 256;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [3:0]  status;
    logic        complete;
    logic [15:0] seq;
    logic [18:0] bytes;
    logic [15:0] held;
  } frag_result_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_stall;
  logic [15:0] packet_sequence = '0;
  logic [7:0] fragment_index = '0, fragment_total = '0;
  logic [10:0] fragment_bytes = '0;
  logic out_valid, out_stall = 0;
  logic [3:0] status;
  logic packet_complete;
  logic [15:0] completed_sequence, buffered_fragments;
  logic [18:0] packet_bytes;

  always #6 clk = ~clk;

  fragment_reassembly_tracker u_dut (.*);

  // predictor state
  logic [15:0] win_dist, cur_seq;
  int held_count;
  logic slot_busy[NSLOT];
  logic [15:0] slot_seq[NSLOT];
  logic [7:0] slot_tot[NSLOT], slot_rcv[NSLOT];
  logic [10:0] slot_last[NSLOT];
  logic [255:0] slot_map[NSLOT];

  frag_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0, stall_pct = 0;
  bit hold_off = 0;
  int quiet_cycles = 0;

  function automatic bit newer(logic [15:0] a, logic [15:0] b);
    logic [15:0] dab, dba;
    dab = a - b;
    dba = b - a;
    return (a > b && dab <= 16'd32768) || (a < b && dba > 16'd32768);
  endfunction

  function automatic void clear_slot(int s);
    slot_busy[s] = 0;
    slot_rcv[s] = 0;
    slot_map[s] = '0;
  endfunction

  function automatic void tracker_reset();
    win_dist = ftr_pkg::MAX_DIST_RESET;
    cur_seq = 0;
    held_count = 0;
    for (int s = 0; s < NSLOT; s++) begin
      slot_seq[s] = 0; slot_tot[s] = 0; slot_last[s] = 0;
      clear_slot(s);
    end
  endfunction

  function automatic frag_result_t track_fragment(logic [15:0] sq, logic [7:0] ix,
                                                  logic [7:0] tt, logic [10:0] by);
    frag_result_t r;
    logic [3:0] st;
    logic [15:0] d, oldest;
    bit far;
    int s, n, sum;
    r = '0;
    st = ftr_pkg::ST_OK;
    if (by == 0 || by > MAXB) st = ftr_pkg::ST_SIZE;
    else if (tt == 0 || tt > MAXF) st = ftr_pkg::ST_COUNT;
    else if (ix >= tt) st = ftr_pkg::ST_INDEX;
    else if (ix != tt - 8'd1 && by != MAXB) st = ftr_pkg::ST_SHORT;
    else begin
      d = sq - cur_seq;
      if (d < 16'd32768) far = d > win_dist;
      else if (d == 16'd32768 && sq < cur_seq) far = 32768 > win_dist;
      else far = 0;
      if (far) st = ftr_pkg::ST_WINDOW;
    end
    s = sq % NSLOT;
    if (st == ftr_pkg::ST_OK && slot_busy[s] && slot_seq[s] != sq) st = ftr_pkg::ST_BUSY;
    if (st == ftr_pkg::ST_OK && !slot_busy[s]) begin
      if (newer(sq, cur_seq)) begin
        oldest = sq - 16'(NSLOT) + 16'd1;
        for (int k = 0; k < NSLOT; k++)
          if (slot_busy[k] && newer(oldest, slot_seq[k])) begin
            held_count = held_count >= slot_rcv[k] ? held_count - slot_rcv[k] : 0;
            clear_slot(k);
          end
        cur_seq = sq;
      end
      clear_slot(s);
      slot_seq[s] = sq;
      slot_tot[s] = tt;
      slot_busy[s] = 1;
    end
    if (st == ftr_pkg::ST_OK && tt != slot_tot[s]) st = ftr_pkg::ST_MISMATCH;
    if (st == ftr_pkg::ST_OK && slot_map[s][ix]) st = ftr_pkg::ST_DUP;
    if (st == ftr_pkg::ST_OK) begin
      slot_map[s][ix] = 1;
      slot_rcv[s] = slot_rcv[s] + 8'd1;
      held_count++;
      if (ix == tt - 8'd1) slot_last[s] = by;
      if (slot_rcv[s] == slot_tot[s]) begin
        n = slot_tot[s];
        sum = (n - 1) * MAXB + slot_last[s];
        r.complete = 1;
        r.seq = sq;
        r.bytes = sum > 524287 ? 19'h7FFFF : 19'(sum);
        held_count = held_count >= n ? held_count - n : 0;
        clear_slot(s);
      end
    end
    r.status = st;
    r.held = held_count > 65535 ? 16'hFFFF : 16'(held_count);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      frag_result_t e;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (packet_complete !== e.complete) begin
          $error("packet_complete exp %0d got %0d", e.complete, packet_complete); errors++;
        end
        if (completed_sequence !== e.seq) begin
          $error("completed_sequence exp %0d got %0d", e.seq, completed_sequence);
          errors++;
        end
        if (packet_bytes !== e.bytes) begin
          $error("packet_bytes exp %0d got %0d", e.bytes, packet_bytes); errors++;
        end
        if (buffered_fragments !== e.held) begin
          $error("buffered_fragments exp %0d got %0d", e.held, buffered_fragments);
          errors++;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk)
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_fragment(logic [15:0] sq, logic [7:0] ix, logic [7:0] tt,
                               logic [10:0] by);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    packet_sequence <= sq;
    fragment_index <= ix;
    fragment_total <= tt;
    fragment_bytes <= by;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(track_fragment(sq, ix, tt, by));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NSLOT + 20) @(posedge clk);
  endtask

  task automatic write_window(logic [15:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ftr_pkg::REG_MAX_DIST;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    win_dist = v;
    @(posedge clk);
  endtask

  // whole packet of tt fragments in random order, last size random
  task automatic send_packet(logic [15:0] sq, int tt);
    int order[$];
    int j, t;
    for (int i = 0; i < tt; i++) order.push_back(i);
    for (int i = tt - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    foreach (order[i])
      send_fragment(sq, 8'(order[i]), 8'(tt),
                    order[i] == tt - 1 ? 11'($urandom_range(MAXB, 1)) : 11'(MAXB));
  endtask

  task automatic test_directed();
    send_fragment(16'd0, 8'd0, 8'd1, 11'd0);        // zero size
    send_fragment(16'd0, 8'd0, 8'd1, 11'd2047);     // oversize
    send_fragment(16'd0, 8'd0, 8'd0, 11'd5);        // zero count
    send_fragment(16'd0, 8'd3, 8'd3, 11'd5);        // index past end
    send_fragment(16'd0, 8'd255, 8'd255, 11'd5);
    send_fragment(16'd0, 8'd0, 8'd2, 11'd100);      // short non-last
    send_fragment(16'd5000, 8'd0, 8'd1, 11'd1);     // out of window
    send_fragment(16'd1, 8'd0, 8'd2, 11'd1024);
    send_fragment(16'd1, 8'd0, 8'd2, 11'd1024);     // duplicate
    send_fragment(16'd1, 8'd0, 8'd3, 11'd1024);     // count mismatch
    send_fragment(16'd257, 8'd0, 8'd1, 11'd7);      // slot busy
    send_fragment(16'd1, 8'd1, 8'd2, 11'd1024);     // complete, full size
    send_fragment(16'd2, 8'd0, 8'd1, 11'd1);        // single fragment
    send_fragment(16'd3, 8'd0, 8'd255, 11'd1024);
    send_fragment(16'd1024, 8'd0, 8'd1, 11'd1);     // near the window edge; evicts seq 3
    send_fragment(16'd65535, 8'd0, 8'd1, 11'd1024); // behind current
    send_fragment(16'h8400, 8'd0, 8'd1, 11'd3);     // distance 32768 case
    send_packet(16'd1030, 255);
    drain();
  endtask

  task automatic test_window_settings();
    logic [15:0] vals[4] = '{16'd0, 16'd65535, 16'd32767, 16'd3};
    foreach (vals[v]) begin
      write_window(vals[v]);
      for (int i = 0; i < 8; i++)
        send_fragment(16'($urandom), 8'd0, 8'd1, 11'($urandom_range(MAXB, 1)));
      send_fragment(cur_seq ^ 16'h8000, 8'd0, 8'd1, 11'd9);
      drain();
    end
    write_window(16'd1024);
  endtask

  task automatic test_random(int n);
    int sent;
    int np;
    logic [15:0] base;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) < 7) begin
        base = cur_seq + 16'($urandom_range(300));
        np = ($urandom_range(9) == 0) ? int'($urandom_range(40, 1)) :
                                        int'($urandom_range(5, 1));
        send_packet(base, np);
        sent += np;
      end else begin
        send_fragment(cur_seq + 16'($urandom_range(2000)) - 16'd500, 8'($urandom),
                      $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(4)),
                      $urandom_range(3) == 0 ? 11'($urandom) : 11'(MAXB));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 20; i++)
        send_fragment(cur_seq + 16'(i), 8'd0, 8'd1, 11'd10);
    join
    drain();
  endtask

  initial begin
    tracker_reset();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_window_settings();
    test_backpressure();
    send_idle_pct = 0;  stall_pct = 0;  test_random(90); drain();
    send_idle_pct = 87; stall_pct = 0;  test_random(90); drain();
    send_idle_pct = 0;  stall_pct = 87; test_random(90); drain();
    send_idle_pct = 31; stall_pct = 31; test_random(90); drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
